[rtl/mlfq_pkg.sv]
// Shared types and constants of the three-level feedback-queue scheduler.
// Used by the controller, the datapath and the top level.
package mlfq_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARRIVE,
		ST_DISPATCH,
		ST_IO,
		ST_EXEC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic arrive;
		logic dispatch;
		logic io;
		logic exec;
		logic finish;
	} cmd_t;

	localparam logic [1:0] QL1 = 2'd0;
	localparam logic [1:0] QL2 = 2'd1;
	localparam logic [1:0] QL3 = 2'd2;
	localparam logic [1:0] QIO = 2'd3;

	localparam logic [0:0] REG_Q1 = 1'b0;
	localparam logic [0:0] REG_Q2 = 1'b1;

endpackage

[rtl/mlfq_three_level_scheduler_tick.sv]
// Top level of the three-level feedback-queue scheduler.
// Instantiates mlfq_ctrl and mlfq_datapath; uses mlfq_pkg.
//
// One request on the slave stream is one scheduler tick. s_tuser carries
// arrival_valid; s_tdata carries the rest of the arrival. Each tick yields
// one result request on the master stream. Once a tick is taken, arrival,
// dispatch, IO and execute run as four sequenced steps of the controller,
// and the result is then copied into the output register in the OUT state
// once that register is free, where it is held until taken. The block
// accepts a new tick only after that copy. The user must write the quanta
// through the configuration port only while the block is idle; the block
// itself does not enforce this. Reset empties all queues, frees the CPU,
// clears the tick counter and restores quanta of 4 and 8. When the receiver
// stalls, the held result stays valid, one more tick can be processed and
// then waits for the output register, and no further tick is accepted.
module mlfq_three_level_scheduler_tick #(
	parameter int MAX_JOBS   = 16,
	parameter int BURST_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_idx,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,  // slot, stamp, first, io, second burst
	input  logic         s_tuser,  // arrival_valid
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata   // time, run v/slot/level/phase, fin v/slot/ta/wait/first, idle
);

	mlfq_pkg::cmd_t cmd;
	logic busy, start, arr_v_q;
	logic [83:0] arr_q;
	logic [TIME_BITS-1:0] now, fin_ta, fin_wait, fin_first;
	logic run_v, run_phase, fin_v, idle, out_v_q;
	logic [3:0] run_slot, fin_slot;
	logic [1:0] run_level;
	logic [143:0] res_q;

	assign s_tready = !busy;
	assign start = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (start) begin
			arr_q <= s_tdata[83:0];
			arr_v_q <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (cmd.finish) out_v_q <= 1'b1;
		else if (m_tready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= {2'd0, idle, 32'(fin_first), 32'(fin_wait), 32'(fin_ta), fin_slot,
				fin_v, run_phase, run_level, run_slot, run_v, 32'(now - 1'b1)};
		end
	end

	mlfq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.out_free(!out_v_q || m_tready), .cmd(cmd), .busy(busy)
	);

	mlfq_datapath #(.MAX_JOBS(MAX_JOBS), .BURST_BITS(BURST_BITS), .TIME_BITS(TIME_BITS))
	u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.a_valid(arr_v_q), .a_slot(arr_q[3:0]), .a_stamp(arr_q[35:4]),
		.a_b1(BURST_BITS'(arr_q[51:36])), .a_io(BURST_BITS'(arr_q[67:52])),
		.a_b2(BURST_BITS'(arr_q[83:68])),
		.now(now), .run_v(run_v), .run_slot(run_slot), .run_level(run_level),
		.run_phase(run_phase), .fin_v(fin_v), .fin_slot(fin_slot), .fin_ta(fin_ta),
		.fin_wait(fin_wait), .fin_first(fin_first), .idle(idle)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata = res_q;

endmodule

[rtl/mlfq_ctrl.sv]
// Sequencing controller of the scheduler: steps one tick through its phases.
// Depends on mlfq_pkg.
module mlfq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              out_free,
	output mlfq_pkg::cmd_t    cmd,
	output logic              busy
);

	mlfq_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mlfq_pkg::ST_IDLE;
		else state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			mlfq_pkg::ST_IDLE:     if (start) state_next = mlfq_pkg::ST_ARRIVE;
			mlfq_pkg::ST_ARRIVE:   state_next = mlfq_pkg::ST_DISPATCH;
			mlfq_pkg::ST_DISPATCH: state_next = mlfq_pkg::ST_IO;
			mlfq_pkg::ST_IO:       state_next = mlfq_pkg::ST_EXEC;
			mlfq_pkg::ST_EXEC:     state_next = mlfq_pkg::ST_OUT;
			mlfq_pkg::ST_OUT:      if (out_free) state_next = mlfq_pkg::ST_IDLE;
			default:               state_next = mlfq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			mlfq_pkg::ST_IDLE:     busy = 1'b0;
			mlfq_pkg::ST_ARRIVE:   cmd.arrive = 1'b1;
			mlfq_pkg::ST_DISPATCH: cmd.dispatch = 1'b1;
			mlfq_pkg::ST_IO:       cmd.io = 1'b1;
			mlfq_pkg::ST_EXEC:     cmd.exec = 1'b1;
			mlfq_pkg::ST_OUT:      cmd.finish = out_free;
			default:               busy = 1'b0;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.arrive |=> cmd.dispatch) else $error("dispatch must follow arrival");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.io |=> cmd.exec) else $error("execute must follow io");
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.arrive, cmd.dispatch, cmd.io, cmd.exec}) <= 1)
		else $error("one phase at a time");

endmodule

[rtl/mlfq_datapath.sv]
// Datapath of the scheduler: job tables, four slot queues, CPU and IO state.
// Depends on mlfq_pkg; driven by mlfq_ctrl commands.
module mlfq_datapath #(
	parameter int MAX_JOBS   = 16,
	parameter int BURST_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mlfq_pkg::cmd_t        cmd,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_idx,
	input  logic [15:0]           cfg_data,
	input  logic                  a_valid,
	input  logic [3:0]            a_slot,
	input  logic [31:0]           a_stamp,
	input  logic [BURST_BITS-1:0] a_b1,
	input  logic [BURST_BITS-1:0] a_io,
	input  logic [BURST_BITS-1:0] a_b2,
	output logic [TIME_BITS-1:0]  now,
	output logic                  run_v,
	output logic [3:0]            run_slot,
	output logic [1:0]            run_level,
	output logic                  run_phase,
	output logic                  fin_v,
	output logic [3:0]            fin_slot,
	output logic [TIME_BITS-1:0]  fin_ta,
	output logic [TIME_BITS-1:0]  fin_wait,
	output logic [TIME_BITS-1:0]  fin_first,
	output logic                  idle
);

	localparam int SW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int SUMW = BURST_BITS + 2;

	logic [15:0] q1_q, q2_q;
	logic [TIME_BITS-1:0] tick_q;
	logic [BURST_BITS-1:0] rb1_q [MAX_JOBS];
	logic [BURST_BITS-1:0] rio_q [MAX_JOBS];
	logic [BURST_BITS-1:0] rb2_q [MAX_JOBS];
	logic [SUMW-1:0] sum_q [MAX_JOBS];
	logic [TIME_BITS-1:0] arr_q [MAX_JOBS];
	logic [TIME_BITS-1:0] first_q [MAX_JOBS];
	logic [MAX_JOBS-1:0] started_q;
	logic [SW-1:0] qmem_q [4][MAX_JOBS];
	logic [SW-1:0] rp_q [4];
	logic [SW-1:0] wp_q [4];
	logic [CW-1:0] cnt_q [4];
	logic cpu_busy_q;
	logic [SW-1:0] cpu_slot_q;
	logic [1:0] cpu_level_q;
	logic [15:0] slice_q;

	logic [SW-1:0] io_head, s;
	logic [BURST_BITS-1:0] io_dec, b1_dec, b2_dec;
	logic [15:0] slice_inc;
	logic [TIME_BITS-1:0] ta;
	logic qexp;

	function automatic logic [SW-1:0] nxt(input logic [SW-1:0] p);
		return (32'(p) + 1 >= MAX_JOBS) ? '0 : p + 1'b1;
	endfunction

	assign io_head = qmem_q[mlfq_pkg::QIO][rp_q[mlfq_pkg::QIO]];
	assign io_dec = (rio_q[io_head] != '0) ? rio_q[io_head] - 1'b1 : '0;
	assign s = cpu_slot_q;
	assign b1_dec = rb1_q[s] - 1'b1;
	assign b2_dec = rb2_q[s] - 1'b1;
	assign slice_inc = slice_q + 16'd1;
	assign qexp = (cpu_level_q == 2'd1 && slice_inc == q1_q) ||
		(cpu_level_q == 2'd2 && slice_inc == q2_q);
	assign ta = now + 1'b1 - arr_q[s];
	assign now = tick_q;
	assign idle = !cpu_busy_q && cnt_q[0] == '0 && cnt_q[1] == '0 &&
		cnt_q[2] == '0 && cnt_q[3] == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q1_q <= 16'd4;
			q2_q <= 16'd8;
			tick_q <= '0;
			started_q <= '0;
			for (int i = 0; i < 4; i++) begin
				rp_q[i] <= '0;
				wp_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			cpu_busy_q <= 1'b0;
			cpu_slot_q <= '0;
			cpu_level_q <= 2'd1;
			slice_q <= '0;
			run_v <= 1'b0;
			fin_v <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == mlfq_pkg::REG_Q1) q1_q <= cfg_data;
			if (cfg_we && cfg_idx == mlfq_pkg::REG_Q2) q2_q <= cfg_data;
			if (cmd.arrive) begin
				run_v <= 1'b0;
				fin_v <= 1'b0;
				run_slot <= '0;
				run_level <= '0;
				run_phase <= 1'b0;
				fin_slot <= '0;
				fin_ta <= '0;
				fin_wait <= '0;
				fin_first <= '0;
				if (a_valid && 32'(a_slot) < MAX_JOBS) begin
					rb1_q[SW'(a_slot)] <= a_b1;
					rio_q[SW'(a_slot)] <= a_io;
					rb2_q[SW'(a_slot)] <= a_b2;
					sum_q[SW'(a_slot)] <= SUMW'(a_b1) + SUMW'(a_io) + SUMW'(a_b2);
					arr_q[SW'(a_slot)] <= TIME_BITS'(a_stamp);
					started_q[SW'(a_slot)] <= 1'b0;
					if (32'(cnt_q[0]) < MAX_JOBS) begin
						qmem_q[0][wp_q[0]] <= SW'(a_slot);
						wp_q[0] <= nxt(wp_q[0]);
						cnt_q[0] <= cnt_q[0] + 1'b1;
					end
				end
			end
			if (cmd.dispatch && !cpu_busy_q) begin
				for (int q = 2; q >= 0; q--) begin
					if (cnt_q[q] != '0 && (q == 0 || (cnt_q[0] == '0 &&
						(q == 1 || cnt_q[1] == '0)))) begin
						cpu_slot_q <= qmem_q[q][rp_q[q]];
						cpu_level_q <= 2'(q + 1);
						cpu_busy_q <= 1'b1;
						slice_q <= '0;
						rp_q[q] <= nxt(rp_q[q]);
						cnt_q[q] <= cnt_q[q] - 1'b1;
						if (!started_q[qmem_q[q][rp_q[q]]]) begin
							started_q[qmem_q[q][rp_q[q]]] <= 1'b1;
							first_q[qmem_q[q][rp_q[q]]] <= now;
						end
					end
				end
			end
			if (cmd.io && cnt_q[3] != '0) begin
				rio_q[io_head] <= io_dec;
				if (io_dec == '0) begin
					rp_q[3] <= nxt(rp_q[3]);
					cnt_q[3] <= cnt_q[3] - 1'b1;
					if (32'(cnt_q[0]) < MAX_JOBS) begin
						qmem_q[0][wp_q[0]] <= io_head;
						wp_q[0] <= nxt(wp_q[0]);
						cnt_q[0] <= cnt_q[0] + 1'b1;
					end
				end
			end
			if (cmd.exec) begin
				tick_q <= tick_q + 1'b1;
				if (cpu_busy_q) begin
					logic term, to_io, demote;
					term = 1'b0;
					to_io = 1'b0;
					demote = 1'b0;
					run_v <= 1'b1;
					run_slot <= 4'(s);
					run_level <= cpu_level_q;
					if (rb1_q[s] != '0) begin
						run_phase <= 1'b0;
						rb1_q[s] <= b1_dec;
						slice_q <= slice_inc;
						if (b1_dec == '0 && rio_q[s] != '0) to_io = 1'b1;
						else if (b1_dec == '0 && rb2_q[s] == '0) term = 1'b1;
						else demote = qexp;
					end else if (rio_q[s] != '0) begin
						run_phase <= 1'b0;
						to_io = 1'b1;
					end else if (rb2_q[s] != '0) begin
						run_phase <= 1'b1;
						rb2_q[s] <= b2_dec;
						slice_q <= slice_inc;
						if (b2_dec == '0) term = 1'b1;
						else demote = qexp;
					end else begin
						run_phase <= 1'b1;
						term = 1'b1;
					end
					if (to_io && 32'(cnt_q[3]) < MAX_JOBS) begin
						qmem_q[3][wp_q[3]] <= s;
						wp_q[3] <= nxt(wp_q[3]);
						cnt_q[3] <= cnt_q[3] + 1'b1;
					end
					if (demote) begin
						if (32'(cnt_q[cpu_level_q]) < MAX_JOBS) begin
							qmem_q[cpu_level_q][wp_q[cpu_level_q]] <= s;
							wp_q[cpu_level_q] <= nxt(wp_q[cpu_level_q]);
							cnt_q[cpu_level_q] <= cnt_q[cpu_level_q] + 1'b1;
						end
					end
					if (to_io || demote || term) cpu_busy_q <= 1'b0;
					if (term) begin
						fin_v <= 1'b1;
						fin_slot <= 4'(s);
						fin_ta <= ta;
						fin_wait <= ta - TIME_BITS'(sum_q[s]);
						fin_first <= first_q[s];
					end
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fin_v |-> run_v) else $error("finish without a running job");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q[0]) <= MAX_JOBS) else $error("level one count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> tick_q == $past(tick_q) + 1'b1) else $error("tick not advanced");

endmodule
